/* hdl/bub2_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bub2_pkg
// Shared constants, types and averaging functions of the 2x bilinear upscaler.
// ----------------------------------------------------------------------------
package bub2_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int SIZE_W  = 11;
    localparam int COORD_W = 11;
    localparam int PIX_W   = 32;
    localparam int CHAN_W  = 8;
    localparam int NCHAN   = PIX_W / CHAN_W;
    localparam int IDX_W   = 1;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;
    localparam int NSLOT   = 9;
    localparam int SLOT_W  = 4;

    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 1'd0;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 1'd1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t             pix;
        pix_t             left;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_row;
        logic             last_col;
    } bub2_item_t;

    function automatic pix_t avg2(pix_t p, pix_t q);
        logic [CHAN_W:0] s;
        pix_t            res;
        res = '0;
        for (int i = 0; i < NCHAN; i++)
        begin
            s = {1'b0, p[i*CHAN_W +: CHAN_W]} + {1'b0, q[i*CHAN_W +: CHAN_W]};
            res[i*CHAN_W +: CHAN_W] = s[CHAN_W:1];
        end
        return res;
    endfunction

    function automatic pix_t avg4(pix_t p, pix_t q, pix_t s, pix_t t);
        logic [CHAN_W+1:0] sum;
        pix_t              res;
        res = '0;
        for (int i = 0; i < NCHAN; i++)
        begin
            sum = {2'b0, p[i*CHAN_W +: CHAN_W]} + {2'b0, q[i*CHAN_W +: CHAN_W]}
                + {2'b0, s[i*CHAN_W +: CHAN_W]} + {2'b0, t[i*CHAN_W +: CHAN_W]};
            res[i*CHAN_W +: CHAN_W] = sum[CHAN_W+1:2];
        end
        return res;
    endfunction

endpackage

/* hdl/bub2_line_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bub2_line_ram
// Single-port line buffer, read-first, with a registered read port.
// ----------------------------------------------------------------------------
module bub2_line_ram (
    input  logic                       clk,
    input  logic                       en,
    input  logic [bub2_pkg::COL_W-1:0] addr,
    input  bub2_pkg::pix_t             wdata,
    output bub2_pkg::pix_t             rdata
);
    import bub2_pkg::*;

    pix_t mem [MAX_WIDTH];
    pix_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg  <= mem[addr];
            mem[addr]  <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/bub2_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bub2_front
// Size registers, position counters, line buffer access and the input stage.
// ----------------------------------------------------------------------------
module bub2_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bub2_pkg::IN_TDATA_W-1:0] s_tdata,  // alpha, red, green, blue
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bub2_pkg::IDX_W-1:0]  cfg_index,
    input  logic [bub2_pkg::SIZE_W-1:0] cfg_data,
    output logic                        ram_en,
    output logic [bub2_pkg::COL_W-1:0]  ram_addr,
    output bub2_pkg::pix_t              ram_wdata,
    output logic                        item_valid,
    output bub2_pkg::bub2_item_t        item,
    input  logic                        item_ready
);
    import bub2_pkg::*;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    pix_t              left_reg;
    logic              valid_reg;
    logic              valid_next;
    bub2_item_t        item_reg;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic              last_col;
    logic              last_row;
    logic              accept;
    pix_t              pix;

    assign pix       = s_tdata[PIX_W-1:0];
    assign cfg_ready = 1'b1;
    assign s_tready  = !valid_reg || item_ready;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        if (width_reg < SIZE_W'(2))
            w_eff = SIZE_W'(2);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = SIZE_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg < SIZE_W'(2))
            h_eff = SIZE_W'(2);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = SIZE_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    assign last_col = (32'(col_reg) + 32'd1) >= 32'(w_eff);
    assign last_row = (32'(row_reg) + 32'd1) >= 32'(h_eff);

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        valid_next = valid_reg;
        if (item_ready)
            valid_next = 1'b0;
        if (accept)
        begin
            valid_next = 1'b1;
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(1024);
            height_reg <= SIZE_W'(1024);
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                    REG_SOURCE_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
            col_reg   <= col_next;
            row_reg   <= row_next;
            valid_reg <= valid_next;
            if (accept)
                left_reg <= pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.pix      <= pix;
            item_reg.left     <= left_reg;
            item_reg.row      <= row_reg;
            item_reg.col      <= col_reg;
            item_reg.last_row <= last_row;
            item_reg.last_col <= last_col;
        end
    end

    assign ram_en     = accept;
    assign ram_addr   = col_reg;
    assign ram_wdata  = pix;
    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/bub2_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bub2_emit
// Interpolation and result sequencer with the output register.
// ----------------------------------------------------------------------------
module bub2_emit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    input  bub2_pkg::bub2_item_t         item,
    output logic                         item_ready,
    input  bub2_pkg::pix_t               up,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bub2_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import bub2_pkg::*;

    logic                   job_valid_reg;
    logic [NSLOT-1:0]       rem_reg;
    logic [NSLOT-1:0]       rem_next;
    logic [NSLOT-1:0]       mask;
    logic [ROW_W-1:0]       row_reg;
    logic [COL_W-1:0]       col_reg;
    pix_t                   centre_reg;
    pix_t                   vert_reg;
    pix_t                   horiz_reg;
    pix_t                   pix_reg;
    pix_t                   upleft_reg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_last_reg;
    logic                   out_free;
    logic                   fire;
    logic                   done;
    logic                   load;
    logic [SLOT_W-1:0]      slot;
    logic [1:0]             sec;
    logic [1:0]             part;
    logic [COORD_W-1:0]     out_row;
    logic [COORD_W-1:0]     out_col;
    pix_t                   out_pix;
    logic [2:0]             sec_en;
    logic [2:0]             part_en;

    assign out_free   = !out_valid_reg || m_tready;
    assign fire       = job_valid_reg && out_free;
    assign done       = fire && (rem_next == '0);
    assign item_ready = !job_valid_reg || done;
    assign load       = item_valid && item_ready;

    assign sec_en  = {item.last_row, 1'b1, item.row != '0};
    assign part_en = {item.last_col, 1'b1, item.col != '0};

    always_comb
    begin
        for (int i = 0; i < NSLOT; i++)
            mask[i] = sec_en[i / 3] && part_en[i % 3];
    end

    always_comb
    begin
        slot = '0;
        for (int i = NSLOT - 1; i >= 0; i--)
            if (rem_reg[i])
                slot = SLOT_W'(i);
        if (slot >= SLOT_W'(6))
            sec = 2'd2;
        else if (slot >= SLOT_W'(3))
            sec = 2'd1;
        else
            sec = 2'd0;
        part     = 2'(slot - SLOT_W'(3) * SLOT_W'(sec));
        rem_next = rem_reg & ~(NSLOT'(1) << slot);
        out_row  = COORD_W'({row_reg, 1'b0}) + COORD_W'(sec) - COORD_W'(1);
        out_col  = COORD_W'({col_reg, 1'b0}) + COORD_W'(part) - COORD_W'(1);
        if (part == 2'd0)
            out_pix = (sec == 2'd0) ? centre_reg : horiz_reg;
        else
            out_pix = (sec == 2'd0) ? vert_reg : pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            rem_reg       <= '0;
            upleft_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                job_valid_reg <= 1'b1;
                rem_reg       <= mask;
                upleft_reg    <= up;
            end
            else if (fire)
            begin
                job_valid_reg <= !done;
                rem_reg       <= rem_next;
            end
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_reg    <= item.row;
            col_reg    <= item.col;
            pix_reg    <= item.pix;
            horiz_reg  <= avg2(item.left, item.pix);
            vert_reg   <= avg2(up, item.pix);
            centre_reg <= avg4(upleft_reg, up, item.left, item.pix);
        end
        if (fire)
        begin
            out_data_reg <= {(OUT_TDATA_W - PIX_W - 2 * COORD_W)'(0), out_pix, out_col, out_row};
            out_last_reg <= rem_next == '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hdl/bilinear_upscale_by_two_top.sv */
`timescale 1ns / 1ps
// Throughput: one result per cycle from the output register while a job is
//   pending and m_tready is high; a source item yields 1 to 9 results, 4 on average per image.
// The result sequencer, emitting one destination pixel per cycle unless stalled, sets the rate.
// Reset clears sizes (1024 x 1024), counters, neighbor pixels and valid flags;
//   the line buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// bilinear_upscale_by_two_top
// 2x bilinear RGBA upscaler with a one-row line buffer.
// ----------------------------------------------------------------------------
module bilinear_upscale_by_two_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bub2_pkg::IN_TDATA_W-1:0]  s_tdata,   // alpha, red, green, blue
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bub2_pkg::OUT_TDATA_W-1:0] m_tdata,   // row, col, alpha, red, green, blue
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bub2_pkg::IDX_W-1:0]       cfg_index,
    input  logic [bub2_pkg::SIZE_W-1:0]      cfg_data
);
    import bub2_pkg::*;

    logic             ram_en;
    logic [COL_W-1:0] ram_addr;
    pix_t             ram_wdata;
    pix_t             ram_rdata;
    logic             item_valid;
    logic             item_ready;
    bub2_item_t       item;

    bub2_line_ram u_ram (
        .clk   (clk),
        .en    (ram_en),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    bub2_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ram_en     (ram_en),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    bub2_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready),
        .up         (ram_rdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

/* hdl/bub2_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bub2_checker
// Port-level checks of the upscaler, bound to the top level.
// ----------------------------------------------------------------------------
module bub2_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bub2_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast,
    input logic                             cfg_ready
);
    import bub2_pkg::*;

    logic [SLOT_W-1:0] run_reg;
    logic [2:0]        pend_reg;
    logic              in_acc;
    logic              out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (out_acc)
                run_reg <= m_tlast ? '0 : run_reg + SLOT_W'(1);
            pend_reg <= pend_reg + 3'(in_acc) - 3'(out_acc && m_tlast);
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !m_tlast |=> m_tvalid)
        else $error("gap inside the results of one item");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg < SLOT_W'(NSLOT))
        else $error("more than nine results for one item");

    a_pending: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd3 && cfg_ready)
        else $error("too many items in flight or config port stalled");

endmodule

bind bilinear_upscale_by_two_top bub2_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x bilinear upscaler. Source pixels stream in
// bursts while the result side stalls on its own pattern. A scoreboard keeps
// its own line buffer, neighbors and counters, predicts every destination
// pixel with its row, column and end-of-run flag, and compares each result
// with the oldest prediction. Image sizes change between phases: clamped
// values, both extremes, and changes in the middle of an image.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
} rgba_t;

typedef struct packed {
    logic [10:0] row;
    logic [10:0] col;
    rgba_t       px;
    logic        run_end;
} dst_pixel_t;

class upscale_scoreboard;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    rgba_t       line_buf[1024];
    rgba_t       left_px;
    rgba_t       upleft_px;
    int          row;
    int          col;
    int          filled;
    int          errors;
    dst_pixel_t  pending_q[$];

    function new();
        width_reg  = 11'd1024;
        height_reg = 11'd1024;
        foreach (line_buf[i])
            line_buf[i] = '0;
        left_px   = '0;
        upleft_px = '0;
        row       = 0;
        col       = 0;
        filled    = 0;
        errors    = 0;
    endfunction

    function int eff_size(logic [10:0] v);
        if (v < 11'd2)
            return 2;
        if (v > 11'd1024)
            return 1024;
        return int'(v);
    endfunction

    function void write_reg(logic [bub2_pkg::IDX_W-1:0] idx, logic [10:0] val);
        if (idx == bub2_pkg::REG_SOURCE_WIDTH)
            width_reg = val;
        else if (idx == bub2_pkg::REG_SOURCE_HEIGHT)
            height_reg = val;
    endfunction

    function rgba_t mid2(rgba_t a, rgba_t b);
        rgba_t res;
        res.alpha = 8'((9'(a.alpha) + 9'(b.alpha)) >> 1);
        res.red   = 8'((9'(a.red)   + 9'(b.red))   >> 1);
        res.green = 8'((9'(a.green) + 9'(b.green)) >> 1);
        res.blue  = 8'((9'(a.blue)  + 9'(b.blue))  >> 1);
        return res;
    endfunction

    function rgba_t mid4(rgba_t a, rgba_t b, rgba_t c, rgba_t d);
        rgba_t res;
        res.alpha = 8'((10'(a.alpha) + 10'(b.alpha) + 10'(c.alpha) + 10'(d.alpha)) >> 2);
        res.red   = 8'((10'(a.red)   + 10'(b.red)   + 10'(c.red)   + 10'(d.red))   >> 2);
        res.green = 8'((10'(a.green) + 10'(b.green) + 10'(c.green) + 10'(d.green)) >> 2);
        res.blue  = 8'((10'(a.blue)  + 10'(b.blue)  + 10'(c.blue)  + 10'(d.blue))  >> 2);
        return res;
    endfunction

    function void push_row(int drow, int c, bit last_col, bit has_left,
                           rgba_t mid, rgba_t here);
        if (has_left)
            pending_q.push_back('{11'(drow), 11'(2 * c - 1), mid, 1'b0});
        pending_q.push_back('{11'(drow), 11'(2 * c), here, 1'b0});
        if (last_col)
            pending_q.push_back('{11'(drow), 11'(2 * c + 1), here, 1'b0});
    endfunction

    function void note_pixel(rgba_t px);
        int    w;
        int    h;
        bit    last_col;
        bit    last_row;
        rgba_t up;
        rgba_t horiz;
        w        = eff_size(width_reg);
        h        = eff_size(height_reg);
        last_col = (col + 1 >= w);
        last_row = (row + 1 >= h);
        up       = line_buf[(col < 1024) ? col : 1023];
        horiz    = mid2(left_px, px);
        if (row >= 1)
            push_row(2 * row - 1, col, last_col, col >= 1,
                     mid4(upleft_px, up, left_px, px), mid2(up, px));
        push_row(2 * row, col, last_col, col >= 1, horiz, px);
        if (last_row)
            push_row(2 * row + 1, col, last_col, col >= 1, horiz, px);
        pending_q[pending_q.size() - 1].run_end = 1'b1;

        upleft_px = up;
        line_buf[(col < 1024) ? col : 1023] = px;
        if (col + 1 > filled)
            filled = col + 1;
        left_px = px;
        if (last_col)
        begin
            col = 0;
            row = last_row ? 0 : row + 1;
        end
        else
        begin
            col = col + 1;
        end
    endfunction

    function void compare(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    function void check_result(dst_pixel_t got);
        dst_pixel_t want;
        if (pending_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none actual row %0d col %0d",
                     $time, got.row, got.col);
            return;
        end
        want = pending_q.pop_front();
        compare("row", want.row, got.row);
        compare("col", want.col, got.col);
        compare("alpha", want.px.alpha, got.px.alpha);
        compare("red", want.px.red, got.px.red);
        compare("green", want.px.green, got.px.green);
        compare("blue", want.px.blue, got.px.blue);
        compare("run_end", want.run_end, got.run_end);
    endfunction
endclass

module tb;
    import bub2_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 380;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;      // alpha, red, green, blue
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;           // row, col, alpha, red, green, blue
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index = '0;
    logic [SIZE_W-1:0]      cfg_data = '0;

    upscale_scoreboard sb;
    int                cycles = 0;
    int                burst_left = 0;
    int                sent = 0;

    bilinear_upscale_by_two_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        dst_pixel_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.row      = m_tdata[10:0];
            got.col      = m_tdata[21:11];
            got.px.alpha = m_tdata[29:22];
            got.px.red   = m_tdata[37:30];
            got.px.green = m_tdata[45:38];
            got.px.blue  = m_tdata[53:46];
            got.run_end  = m_tlast;
            sb.check_result(got);
        end
    end

    // result-side stall pattern: long open stretches or short on/off runs
    initial
    begin
        int  hold;
        bit  level;
        hold  = 0;
        level = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    level = 1'b1;
                    hold  = $urandom_range(30, 80);
                end
                else
                begin
                    level = !level;
                    hold  = level ? $urandom_range(1, 6) : $urandom_range(1, 5);
                end
            end
            hold--;
            m_tready <= level;
        end
    end

    function automatic rgba_t random_pixel();
        rgba_t px;
        px = $urandom;
        if ($urandom_range(0, 9) == 0)
        begin
            px.alpha = {8{px.alpha[0]}};
            px.red   = {8{px.red[0]}};
            px.green = {8{px.green[0]}};
            px.blue  = {8{px.blue[0]}};
        end
        return px;
    endfunction

    function automatic rgba_t pattern_pixel(int k);
        case (k % 8)
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'hFF00_FF00;
            3: return 32'h00FF_00FF;
            4: return 32'h0101_0101;
            5: return 32'hFEFE_FEFE;
            6: return 32'h7F80_017F;
            default: return random_pixel();
        endcase
    endfunction

    task automatic send_pixel(input rgba_t px);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 50)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {px.blue, px.green, px.red, px.alpha};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_pixel(px);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic reconfigure(input bit set_w, input logic [SIZE_W-1:0] wv,
                               input bit set_h, input logic [SIZE_W-1:0] hv);
        drain();
        // keep reads of the line buffer inside entries already written
        if (set_w && sb.row != 0 && sb.eff_size(wv) > sb.filled)
            wv = SIZE_W'(sb.filled);
        if (set_w)
            write_reg(REG_SOURCE_WIDTH, wv);
        if (set_h)
            write_reg(REG_SOURCE_HEIGHT, hv);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int                n;
        int                w;
        int                h;
        int                to_end;
        int                sel;
        int                start;
        logic [SIZE_W-1:0] wv;
        logic [SIZE_W-1:0] hv;

        sb = new();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // start a row at reset sizes
        for (int k = 0; k < 4; k++)
            send_pixel(pattern_pixel(k));
        // clamp both sizes low; the open row ends at once and the image is 2x2
        reconfigure(1'b1, 11'd1, 1'b1, 11'd0);
        for (int k = 4; k < 7; k++)
            send_pixel(pattern_pixel(k));
        // clamp both sizes high, then shrink mid-row
        reconfigure(1'b1, 11'd2047, 1'b1, 11'd2047);
        for (int k = 0; k < 6; k++)
            send_pixel(pattern_pixel(k + 1));
        reconfigure(1'b1, 11'd3, 1'b1, 11'd3);
        for (int k = 0; k < 7; k++)
            send_pixel(pattern_pixel(k + 2));
        reconfigure(1'b1, 11'd1024, 1'b1, 11'd2);
        for (int k = 0; k < 3; k++)
            send_pixel(pattern_pixel(k + 5));

        start = sent;
        while (sent - start < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 19);
            if (sel == 0)
                wv = $urandom_range(0, 1);
            else if (sel == 1)
                wv = $urandom_range(1025, 2047);
            else if (sel == 2)
                wv = 11'd1024;
            else
                wv = $urandom_range(2, 8);
            sel = $urandom_range(0, 19);
            if (sel == 0)
                hv = $urandom_range(0, 1);
            else if (sel == 1)
                hv = $urandom_range(1025, 2047);
            else if (sel == 2)
                hv = 11'd1024;
            else
                hv = $urandom_range(2, 6);
            reconfigure($urandom_range(0, 3) != 0, wv, $urandom_range(0, 3) != 0, hv);

            w      = sb.eff_size(sb.width_reg);
            h      = sb.eff_size(sb.height_reg);
            to_end = ((sb.col >= w - 1) ? 1 : w - sb.col)
                   + ((sb.row >= h - 1) ? 0 : h - 1 - sb.row) * w;
            n = ($urandom_range(0, 4) < 3) ? to_end : $urandom_range(1, to_end);
            if (n > 40)
                n = $urandom_range(8, 40);
            repeat (n)
                send_pixel(random_pixel());
        end

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

/* bilinear_upscale_by_two_top.f */
hdl/bub2_pkg.sv
hdl/bub2_line_ram.sv
hdl/bub2_front.sv
hdl/bub2_emit.sv
hdl/bilinear_upscale_by_two_top.sv
hdl/bub2_checker.sv
verif/tb.sv
